/* hw/rtl/nalsplit_pkg.sv */
package nalsplit_pkg;

   // Largest access unit that the position counter is meant to cover.
   localparam logic [32:0] MAX_UNIT_BYTES = 33'd16777216;

   localparam int POS_W   = 24;
   localparam int HDR_W   = 6;
   localparam int ZRUN_W  = 2;

   // Positions count up to this value and then stick.
   localparam logic [32:0] POS_LIMIT_WIDE =
      ((MAX_UNIT_BYTES - 33'd1) > 33'h0FF_FFFF) ? 33'h0FF_FFFF : (MAX_UNIT_BYTES - 33'd1);
   localparam logic [POS_W-1:0] POS_LIMIT = POS_LIMIT_WIDE[POS_W-1:0];

   localparam logic [POS_W-1:0] SIZE_MAX   = '1;
   localparam logic [ZRUN_W-1:0] ZRUN_MAX  = 2'd3;
   localparam logic [ZRUN_W-1:0] ZRUN_CODE = 2'd2;
   localparam logic [7:0] CODE_BYTE        = 8'h01;

   typedef struct packed {
      logic [HDR_W-1:0] nal_type;
      logic [HDR_W-1:0] nuh_layer;
      logic [POS_W-1:0] nal_offset;
      logic [POS_W-1:0] unit_bytes;
      logic             size_overflow;
   } nal_result_type;

endpackage

/* hw/rtl/annexb_nal_splitter.sv */
// Channel   Direction  Beat contents
// req_      in         tdata[7:0] data_byte; tlast marks the final byte of an access unit
// rsp_      out        tdata: nal_type, nuh_layer, nal_offset, unit_bytes; tuser: size_overflow
//
// One byte is taken per clock while no stalled result holds bytes back. A byte sits in
// the input register, is scanned there against the start-code state, and any finished
// NAL unit lands in the result register at the edge that retires the byte.
// Reset is synchronous and clears the scan state and both valid flags.
// A stalled result only holds bytes back when the byte in the input register would
// itself close a unit; bytes that produce nothing keep flowing.
module annexb_nal_splitter
   import nalsplit_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // [5:0] nal_type, [11:6] nuh_layer,
                                    // [35:12] nal_offset, [59:36] unit_bytes, zero above
   output logic        rsp_tuser    // [0] size_overflow
);

   logic           in_valid_ff, in_valid_in;
   logic [7:0]     in_byte_ff, in_byte_in;
   logic           in_last_ff, in_last_in;

   logic           step;
   logic           emit;
   logic           out_free;
   nal_result_type scan_result;
   nal_result_type out_result;

   // The scanned beat retires when it produces nothing, or when the result register
   // can take its NAL unit this cycle.
   assign step       = in_valid_ff && (!emit || out_free);
   assign req_tready = !in_valid_ff || step;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      in_last_in  = in_last_ff;
      if (req_tready) begin
         in_valid_in = req_tvalid;
         in_byte_in  = req_tdata;
         in_last_in  = req_tlast;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
      in_last_ff <= in_last_in;
   end

   nalsplit_scan u_scan (
      .clock     (clock),
      .reset     (reset),
      .data_byte (in_byte_ff),
      .unit_end  (in_last_ff),
      .step      (step),
      .emit      (emit),
      .result    (scan_result)
   );

   nalsplit_out_stage u_out (
      .clock      (clock),
      .reset      (reset),
      .load       (step && emit),
      .result     (scan_result),
      .free       (out_free),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_result (out_result)
   );

   assign rsp_tdata = {4'b0000, out_result.unit_bytes, out_result.nal_offset,
                       out_result.nuh_layer, out_result.nal_type};
   assign rsp_tuser = out_result.size_overflow;

endmodule

/* hw/rtl/nalsplit_scan.sv */
module nalsplit_scan
   import nalsplit_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic [7:0]     data_byte,
   input  logic           unit_end,
   input  logic           step,
   output logic           emit,
   output nal_result_type result
);

   logic [ZRUN_W-1:0] zero_run_ff, zero_run_in;
   logic              inside_ff, inside_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [POS_W-1:0]  start_ff, start_in;
   logic [HDR_W-1:0]  type_ff, type_in;
   logic [HDR_W-1:0]  layer_ff, layer_in;
   logic              sat_ff, sat_in;

   logic              over;
   logic [POS_W-1:0]  pos_next;
   logic [POS_W:0]    start_plus1;
   logic              hit0;
   logic              hit1;
   logic [HDR_W-1:0]  type_cur;
   logic [HDR_W-1:0]  layer_cur;
   logic              code;
   logic [POS_W-1:0]  zeros;
   logic [POS_W-1:0]  end_code;
   logic [POS_W:0]    end_pos;
   logic [POS_W:0]    size_wide;
   logic              emit_cand;

   always_comb begin
      over        = (pos_ff >= POS_LIMIT);
      pos_next    = over ? POS_LIMIT : pos_ff + 1'b1;
      start_plus1 = {1'b0, start_ff} + 1'b1;
      hit0        = inside_ff && (pos_ff == start_ff);
      hit1        = inside_ff && !hit0 && ({1'b0, pos_ff} == start_plus1);

      // The header bytes are captured as they pass; a unit closed on its
      // second byte already needs the updated layer id.
      type_cur  = hit0 ? data_byte[6:1] : type_ff;
      layer_cur = hit0 ? {data_byte[0], {(HDR_W-1){1'b0}}}
                : hit1 ? {layer_ff[HDR_W-1], data_byte[7:3]}
                : layer_ff;

      code     = (data_byte == CODE_BYTE) && (zero_run_ff >= ZRUN_CODE);
      zeros    = {{(POS_W-ZRUN_W){1'b0}}, zero_run_ff};
      end_code = (pos_ff >= zeros) ? pos_ff - zeros : '0;
      end_pos  = code ? {1'b0, end_code} : {1'b0, pos_ff} + 1'b1;

      size_wide = (end_pos > {1'b0, start_ff}) ? end_pos - {1'b0, start_ff} : '0;
      emit_cand = inside_ff && (code || unit_end);
      emit      = emit_cand && (size_wide >= 2);

      result.nal_type      = type_cur;
      result.nuh_layer     = layer_cur;
      result.nal_offset    = start_ff;
      result.unit_bytes    = size_wide[POS_W] ? SIZE_MAX : size_wide[POS_W-1:0];
      result.size_overflow = sat_ff | size_wide[POS_W];

      zero_run_in = zero_run_ff;
      inside_in   = inside_ff;
      pos_in      = pos_ff;
      start_in    = start_ff;
      type_in     = type_ff;
      layer_in    = layer_ff;
      sat_in      = sat_ff;
      if (step) begin
         if (unit_end) begin
            zero_run_in = '0;
            inside_in   = 1'b0;
            pos_in      = '0;
            start_in    = '0;
            type_in     = '0;
            layer_in    = '0;
            sat_in      = 1'b0;
         end else begin
            type_in  = type_cur;
            layer_in = layer_cur;
            pos_in   = pos_next;
            sat_in   = sat_ff | over;
            if (code) begin
               inside_in   = 1'b1;
               start_in    = pos_next;
               zero_run_in = '0;
            end else if (data_byte == 8'h00) begin
               zero_run_in = (zero_run_ff < ZRUN_MAX) ? zero_run_ff + 1'b1 : ZRUN_MAX;
            end else begin
               zero_run_in = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         zero_run_ff <= '0;
         inside_ff   <= 1'b0;
         pos_ff      <= '0;
         start_ff    <= '0;
         type_ff     <= '0;
         layer_ff    <= '0;
         sat_ff      <= 1'b0;
      end else begin
         zero_run_ff <= zero_run_in;
         inside_ff   <= inside_in;
         pos_ff      <= pos_in;
         start_ff    <= start_in;
         type_ff     <= type_in;
         layer_ff    <= layer_in;
         sat_ff      <= sat_in;
      end
   end

endmodule

/* hw/rtl/nalsplit_out_stage.sv */
module nalsplit_out_stage
   import nalsplit_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           load,
   input  nal_result_type result,
   output logic           free,
   output logic           out_valid,
   input  logic           out_ready,
   output nal_result_type out_result
);

   logic           valid_ff, valid_in;
   nal_result_type result_ff, result_in;

   always_comb begin
      free      = !valid_ff || out_ready;
      valid_in  = load ? 1'b1 : (valid_ff && !out_ready);
      result_in = load ? result : result_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      result_ff <= result_in;
   end

   assign out_valid  = valid_ff;
   assign out_result = result_ff;

endmodule

/* test/tb_annexb_nal_splitter.sv */
`timescale 1ns / 100ps

import nalsplit_pkg::*;

// Tracks the start-code scan of an Annex B access unit byte by byte and keeps
// the NAL unit descriptors that the splitter has still to deliver, oldest first.
class nal_unit_tracker;

   nal_result_type expected_units[$];
   int unsigned errors;
   int unsigned units_checked;

   // Scan state of the access unit in progress.
   bit [1:0]        zero_count;
   bit              in_payload;
   longint unsigned position;
   longint unsigned start_pos;
   bit [HDR_W-1:0]  cur_type;
   bit [HDR_W-1:0]  cur_layer;
   bit              pos_clipped;

   function new();
      clear_scan();
   endfunction

   function void clear_scan();
      zero_count  = '0;
      in_payload  = 1'b0;
      position    = 0;
      start_pos   = 0;
      cur_type    = '0;
      cur_layer   = '0;
      pos_clipped = 1'b0;
   endfunction

   function int pending();
      return expected_units.size();
   endfunction

   // Closes the open payload at stop_pos (exclusive). Payloads shorter than two
   // bytes carry no full header and are dropped.
   function void close_payload(longint unsigned stop_pos);
      nal_result_type unit;
      longint unsigned size;
      bit flag;
      size = (stop_pos > start_pos) ? stop_pos - start_pos : 0;
      flag = pos_clipped;
      if (size < 2) return;
      if (size > SIZE_MAX) begin
         size = SIZE_MAX;
         flag = 1'b1;
      end
      unit.nal_type      = cur_type;
      unit.nuh_layer     = cur_layer;
      unit.nal_offset    = start_pos[POS_W-1:0];
      unit.unit_bytes    = size[POS_W-1:0];
      unit.size_overflow = flag;
      expected_units = {expected_units, unit};
   endfunction

   // Called for every byte the splitter accepts.
   function void take_byte(logic [7:0] b, logic last);
      longint unsigned at;
      longint unsigned nxt;
      bit over;
      bit is_code;
      at   = position;
      nxt  = (at < POS_LIMIT) ? at + 1 : POS_LIMIT;
      over = (at >= POS_LIMIT);

      // The first two payload bytes carry the NAL header.
      if (in_payload) begin
         if (at == start_pos) begin
            cur_type  = b[6:1];
            cur_layer = {b[0], 5'd0};
         end else if (at == start_pos + 1) begin
            cur_layer = {cur_layer[5], b[7:3]};
         end
      end

      is_code = (b == CODE_BYTE) && (zero_count >= ZRUN_CODE);
      if (is_code) begin
         // The counted zeros belong to the start code, not the payload.
         if (in_payload) close_payload((at >= zero_count) ? at - zero_count : 0);
         in_payload = 1'b1;
         start_pos  = nxt;
         if (over) pos_clipped = 1'b1;
         zero_count = '0;
      end else if (b == 8'h00) begin
         if (zero_count < ZRUN_MAX) zero_count++;
      end else begin
         zero_count = '0;
      end

      if (last) begin
         if (!is_code && in_payload) close_payload(at + 1);
         clear_scan();
      end else begin
         position = nxt;
         if (over) pos_clipped = 1'b1;
      end
   endfunction

   function void report(string field, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
         errors++;
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
      end
   endfunction

   // Called for every descriptor the splitter hands over.
   function void match_unit(logic [63:0] data, logic flag);
      nal_result_type want;
      if (expected_units.size() == 0) begin
         errors++;
         $display("%0t: NAL descriptor with none expected, expected nothing, actual %h/%b",
                  $time, data, flag);
         return;
      end
      want = expected_units.pop_front();
      units_checked++;
      report("nal_type", 64'(want.nal_type), 64'(data[5:0]));
      report("nuh_layer", 64'(want.nuh_layer), 64'(data[11:6]));
      report("nal_offset", 64'(want.nal_offset), 64'(data[35:12]));
      report("unit_bytes", 64'(want.unit_bytes), 64'(data[59:36]));
      report("tdata padding", 64'd0, 64'(data[63:60]));
      report("size_overflow", 64'(want.size_overflow), 64'(flag));
   endfunction
endclass

module tb_annexb_nal_splitter;
   import nalsplit_pkg::*;

   // Worst case is far below this: roughly 730 bytes, each waiting out a sender
   // gap and a receiver stall, plus one long receiver hold-off.
   localparam int CYCLE_LIMIT   = 300000;
   localparam int RANDOM_BYTES  = 600;
   localparam int HOLD_CYCLES   = 400;
   // Results leave through the input register and then the result register; the margin also covers byte stalls.
   localparam int SETTLE_CYCLES = 20;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;   // [7:0] data_byte
   logic        req_tlast;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [63:0] rsp_tdata;   // [5:0] nal_type, [11:6] nuh_layer,
                             // [35:12] nal_offset, [59:36] unit_bytes, zero above
   logic        rsp_tuser;   // [0] size_overflow

   annexb_nal_splitter uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   nal_unit_tracker tracker = new();

   int unsigned cycles = 0;
   int unsigned bytes_sent;
   int unsigned units_sent;
   int unsigned burst_left;
   logic        hold_off_req;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Every beat on either channel is seen here, at the edge that accepts it. All
   // stimulus changes through nonblocking assignments, so the values read here
   // are the ones present before the edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) tracker.take_byte(req_tdata, req_tlast);
         if (rsp_tvalid && rsp_tready) tracker.match_unit(rsp_tdata, rsp_tuser);
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("%0t: run exceeded %0d cycles, %0d descriptors still outstanding",
                  $time, CYCLE_LIMIT, tracker.pending());
         $display("tb: failure");
         $finish;
      end
   end

   // Receiver: back-pressure comes in segments of random length, either always
   // ready, mostly ready or mostly stalled. A hold-off request from the stimulus
   // side drops tready for a long stretch so that the splitter backs up into its
   // input channel.
   initial begin
      int seg_left;
      int mode;
      int hold_left;
      bit hold_taken;
      seg_left   = 0;
      mode       = 0;
      hold_left  = 0;
      hold_taken = 1'b0;
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_req && !hold_taken) begin
            hold_left  = HOLD_CYCLES;
            hold_taken = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            if (seg_left == 0) begin
               seg_left = $urandom_range(5, 60);
               mode     = $urandom_range(0, 2);
            end
            seg_left--;
            case (mode)
               0:       rsp_tready <= 1'b1;
               1:       rsp_tready <= ($urandom_range(0, 3) != 0);
               default: rsp_tready <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   // The sender offers bytes in bursts. Between bursts it drops tvalid for a random
   // gap; now and then a burst is long enough to stream without a gap.
   task automatic pace();
      if (burst_left == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = ($urandom_range(0, 4) == 0) ? 100 : $urandom_range(1, 12);
      end
      burst_left--;
   endtask

   // Presents one byte and returns at the edge that accepts it. A following call
   // drives the next beat in the same step, so tvalid stays high across bytes of a burst.
   task automatic send_byte(input logic [7:0] b, input logic last);
      pace();
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      bytes_sent++;
   endtask

   task automatic send_unit(input logic [7:0] au[$]);
      foreach (au[i]) send_byte(au[i], i == au.size() - 1);
      units_sent++;
   endtask

   // Stops offering bytes until every predicted descriptor has been delivered.
   // The first edge lets the monitor note the byte accepted last.
   task automatic wait_for_results();
      req_tvalid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (tracker.pending() != 0) @(posedge clock);
   endtask

   // Payload bytes lean toward zeros and ones so that emulation-like zero runs
   // and start codes hidden inside payloads show up often.
   function automatic logic [7:0] payload_byte();
      case ($urandom_range(0, 9))
         0, 1:    return 8'h00;
         2:       return CODE_BYTE;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // Builds one access unit. Most are well formed: optional junk ahead of the
   // first start code, then a few NAL units behind 3- or 4-byte start codes, with
   // some long zero runs, short or empty payloads and a start code on the very
   // last byte. The rest is pure noise or a well-formed unit with a byte spoiled.
   task automatic send_random_unit();
      logic [7:0] au[$];
      int nal_count;
      int len;
      int zeros;
      if ($urandom_range(0, 9) == 0) begin
         repeat ($urandom_range(1, 30)) au = {au, 8'($urandom_range(0, 255))};
      end else begin
         if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 4)) au = {au, payload_byte()};
         nal_count = $urandom_range(1, 6);
         repeat (nal_count) begin
            case ($urandom_range(0, 9))
               0:       zeros = 1;
               1, 2:    zeros = $urandom_range(4, 6);
               default: zeros = $urandom_range(2, 3);
            endcase
            repeat (zeros) au = {au, 8'h00};
            au = {au, CODE_BYTE};
            len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 2) : $urandom_range(2, 14);
            repeat (len) au = {au, payload_byte()};
         end
         if ($urandom_range(0, 7) == 0) begin
            au = {au, 8'h00, 8'h00, CODE_BYTE};
         end
         if ($urandom_range(0, 9) == 0)
            au[$urandom_range(0, au.size() - 1)] = 8'($urandom_range(0, 255));
      end
      send_unit(au);
   endtask

   initial begin
      logic [7:0] au[$];
      bit hold_done;
      bit drain_done;
      bytes_sent   = 0;
      units_sent   = 0;
      burst_left   = 0;
      hold_done    = 1'b0;
      drain_done   = 1'b0;
      reset        <= 1'b1;
      req_tvalid   <= 1'b0;
      req_tdata    <= '0;
      req_tlast    <= 1'b0;
      hold_off_req <= 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Junk ahead of the first start code, a 3-byte code with an all-ones type
      // header, a 4-byte code with an all-zeros type and the top layer bit, then a
      // one-byte payload closed by the end of the access unit.
      au = '{8'hFF, 8'h00, 8'h00, CODE_BYTE, 8'h7E, 8'hF8,
             8'h00, 8'h00, 8'h00, CODE_BYTE, 8'h81, 8'h07,
             8'h00, 8'h00, CODE_BYTE, 8'h40};
      send_unit(au);
      // Five zeros ahead of a start code: the two oldest stay in the payload. The
      // next payload is a single byte, and the access unit ends on a start code.
      au = '{8'h00, 8'h00, CODE_BYTE, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
             CODE_BYTE, 8'h02, 8'h00, 8'h00, CODE_BYTE};
      send_unit(au);
      // An access unit of one byte with no start code at all.
      au = '{8'h00};
      send_unit(au);
      wait_for_results();

      while (bytes_sent < RANDOM_BYTES) begin
         send_random_unit();
         if (!hold_done && bytes_sent > RANDOM_BYTES / 3) begin
            // Keep offering bytes while the receiver holds off.
            hold_off_req <= 1'b1;
            hold_done = 1'b1;
         end
         if (!drain_done && bytes_sent > 2 * RANDOM_BYTES / 3) begin
            wait_for_results();
            drain_done = 1'b1;
         end
      end

      wait_for_results();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Scanned %0d bytes in %0d access units; %0d NAL descriptors checked.",
               bytes_sent, units_sent, tracker.units_checked);
      $display("Covered junk, long zero runs, short payloads, start codes at unit end, stalls.");
      if (tracker.errors == 0 && tracker.pending() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end
endmodule

/* files.f */
hw/rtl/nalsplit_pkg.sv
hw/rtl/nalsplit_scan.sv
hw/rtl/nalsplit_out_stage.sv
hw/rtl/annexb_nal_splitter.sv
test/tb_annexb_nal_splitter.sv
